### design/fpsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package fpsd_pkg;
   localparam int MaxIterations = 16;
   localparam int FracBits      = 8;
   localparam int IterWidth     = $clog2(MaxIterations + 1);
   // Scaled operand is a 31-bit positive value shifted by FracBits.
   localparam int DivWidth      = 31 + FracBits;
   localparam int EstWidth      = 32;
   localparam int CntWidth      = $clog2(DivWidth + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQR,
      ST_SUM,
      ST_INIT,
      ST_DIV,
      ST_UPDATE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic square;
      logic sum;
      logic init;
      logic div_start;
      logic div_step;
      logic update;
   } cmd_type;

   typedef struct packed {
      logic nonpos;
      logic div_last;
      logic converged;
   } stat_type;
endpackage
`default_nettype wire

### design/fpsd_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module fpsd_datapath
   import fpsd_pkg::*;
(
   input  wire logic                  clock,
   input  wire cmd_type               cmd,
   input  wire logic signed [31:0]    value,
   input  wire logic signed [31:0]    ax,
   input  wire logic signed [31:0]    ay,
   input  wire logic signed [31:0]    bx,
   input  wire logic signed [31:0]    by,
   output stat_type                   stat,
   output logic [30:0]                result
);
   logic signed [31:0] v_ff, v_in, dx_ff, dx_in, dy_ff, dy_in;
   logic [63:0]       sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic [EstWidth-1:0] est_ff, est_in;
   logic [DivWidth-1:0] quo_ff, quo_in;
   logic [EstWidth:0]   rem_ff, rem_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;
   logic [63:0]       sum;
   logic [EstWidth:0] trial;
   logic [EstWidth:0] next_full;
   logic [EstWidth-1:0] next_est;
   logic [DivWidth-1:0] scaled;

   assign sum       = sqx_ff + sqy_ff;
   assign scaled    = {v_ff[30:0], {FracBits{1'b0}}};
   assign trial     = {rem_ff[EstWidth-1:0], quo_ff[DivWidth-1]} - {1'b0, est_ff};
   // The quotient never exceeds 32 bits, since the estimate stays at or above the root.
   assign next_full = {1'b0, est_ff} + (EstWidth+1)'(quo_ff);
   assign next_est  = next_full[EstWidth:1];

   always_comb begin
      v_in = v_ff; dx_in = dx_ff; dy_in = dy_ff;
      sqx_in = sqx_ff; sqy_in = sqy_ff; est_in = est_ff;
      quo_in = quo_ff; rem_in = rem_ff; cnt_in = cnt_ff;
      if (cmd.load) begin
         v_in   = value;
         dx_in  = ax - bx;
         dy_in  = ay - by;
      end
      if (cmd.square) begin
         sqx_in = 64'(64'(signed'(dx_ff)) * 64'(signed'(dx_ff)));
         sqy_in = 64'(64'(signed'(dy_ff)) * 64'(signed'(dy_ff)));
      end
      if (cmd.sum) v_in = sum[FracBits+31:FracBits];
      if (cmd.init) begin
         est_in = (v_ff > 32'sd256) ? v_ff : 32'd256;
      end
      if (cmd.div_start) begin
         quo_in = scaled;
         rem_in = '0;
         cnt_in = CntWidth'(DivWidth);
      end
      if (cmd.div_step) begin
         // One restoring step: shift the next dividend bit in, try subtract.
         if (!trial[EstWidth]) begin
            rem_in = trial;
            quo_in = {quo_ff[DivWidth-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[EstWidth-1:0], quo_ff[DivWidth-1]};
            quo_in = {quo_ff[DivWidth-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
      end
      if (cmd.update) est_in = next_est;
   end

   always_ff @(posedge clock) begin
      v_ff <= v_in; dx_ff <= dx_in; dy_ff <= dy_in;
      sqx_ff <= sqx_in; sqy_ff <= sqy_in; est_ff <= est_in;
      quo_ff <= quo_in; rem_ff <= rem_in; cnt_ff <= cnt_in;
   end

   assign stat.nonpos    = (v_ff[31] || v_ff == 32'sd0);
   assign stat.div_last  = (cnt_ff == CntWidth'(1));
   assign stat.converged = (next_est == est_ff);
   assign result         = stat.nonpos ? 31'd0 : est_ff[30:0];
endmodule
`default_nettype wire

### design/fpsd_control.sv
`timescale 1ns / 1ps
`default_nettype none
module fpsd_control
   import fpsd_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     start,
   input  wire logic     command,
   input  wire stat_type stat,
   output cmd_type       cmd,
   output logic          busy,
   output logic          rsp_valid
);
   state_type state_ff, state_in;
   logic [IterWidth-1:0] iter_ff, iter_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         iter_ff  <= '0;
      end else begin
         state_ff <= state_in;
         iter_ff  <= iter_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      iter_in   = iter_ff;
      cmd       = '0;
      rsp_valid = 1'b0;
      busy      = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = command ? ST_SQR : ST_INIT;
            end
         end
         ST_SQR: begin
            cmd.square = 1'b1;
            state_in   = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = ST_INIT;
         end
         ST_INIT: begin
            cmd.init      = 1'b1;
            cmd.div_start = 1'b1;
            iter_in       = '0;
            state_in      = stat.nonpos ? ST_DONE : ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            iter_in = iter_ff + 1'b1;
            if (stat.converged ||
                iter_ff == IterWidth'(MaxIterations - 1)) begin
               if (!stat.converged) cmd.update = 1'b1;
               state_in = ST_DONE;
            end else begin
               cmd.update    = 1'b1;
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end
         end
         ST_DONE: begin
            rsp_valid = 1'b1;
            state_in  = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule
`default_nettype wire

### design/fixed_point_sqrt_and_distance.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Ports                                   Handshake
// request   req_command, req_value, req_ax..req_by  start && !busy
// response  rsp_result                              rsp_valid, one cycle
//
// For a square root, rsp_valid rises after k Newton steps, counted from the word
// being accepted, where k is 1 to 16; a distance first forms the squares and
// their sum.
// Each step is a division by the 39-bit radix-2 divider followed by an update.
// A nonpositive operand returns 0 right after the initial check.
// Reset is synchronous and returns the controller to idle.
// The receiver cannot stall: each word is shown for exactly one cycle.
module fixed_point_sqrt_and_distance
   import fpsd_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic               req_command,
   input  wire logic signed [31:0] req_value,
   input  wire logic signed [31:0] req_ax,
   input  wire logic signed [31:0] req_ay,
   input  wire logic signed [31:0] req_bx,
   input  wire logic signed [31:0] req_by,
   output logic                    rsp_valid,
   output logic [30:0]             rsp_result
);
   cmd_type  cmd;
   stat_type stat;

   // The controller sequences load, squaring, the divider and the update.
   fpsd_control u_control (
      .clock(clock), .reset(reset), .start(start), .command(req_command),
      .stat(stat), .cmd(cmd), .busy(busy), .rsp_valid(rsp_valid)
   );

   // The datapath holds the operand, estimate and the shared divider.
   fpsd_datapath u_datapath (
      .clock(clock), .cmd(cmd), .value(req_value),
      .ax(req_ax), .ay(req_ay), .bx(req_bx), .by(req_by),
      .stat(stat), .result(rsp_result)
   );

   // A response never appears while idle on the cycle before.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy)) else $error("response without work");
   // After a response the block is free.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy) else $error("busy after response");
   // Accepting a word makes the block busy.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("start not taken");
endmodule
`default_nettype wire
